/* rtl/core/max_heap_priority_queue_unit_defines.svh */
// ----------------------------------------------------------------------------
// Heap priority queue assertion macros
// Clocked, reset-qualified property checks used by the heap sequencer.
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define HPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Expression must never be true outside reset.
`define HPQ_ASSERT_NEVER(lbl, expr, msg) \
  `HPQ_ASSERT(lbl, !(expr), msg)

`endif

/* rtl/core/hpq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heap priority queue package
// Sizes, opcodes, sequencer states and the memory request bundle.
// ----------------------------------------------------------------------------
package hpq_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned FW    = 11;
  localparam int unsigned VW    = 32;
  // index arithmetic width: holds 2k+2 and any 11-bit port value
  localparam int unsigned IW    = (AW + 2 > FW) ? AW + 2 : FW;

  localparam logic [FW-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_EXTRACT = 2'd0,
    OP_INSERT  = 2'd1,
    OP_DELETE  = 2'd2,
    OP_UNUSED  = 2'd3
  } op_e;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_FETCH    = 6'b000010,
    ST_RISE     = 6'b000100,
    ST_RISE_CMP = 6'b001000,
    ST_SINK     = 6'b010000,
    ST_SINK_CMP = 6'b100000
  } state_e;

  typedef struct packed {
    logic                 we;
    logic [AW-1:0]        waddr;
    logic signed [VW-1:0] wdata;
    logic [AW-1:0]        raddr_a;
    logic [AW-1:0]        raddr_b;
  } ram_req_t;

endpackage
`default_nettype wire

/* rtl/core/hpq_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heap storage RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module hpq_ram #(
  parameter int unsigned DW    = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DW-1:0]            wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [DW-1:0]            rdata_a_o,
  output logic      [DW-1:0]            rdata_b_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
`default_nettype wire

/* rtl/core/hpq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heap priority queue sequencer
// Runs extract, insert and delete as hole-based sift-up / sift-down walks
// over the heap RAM, each level taking a read state and a compare state.
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_unit_defines.svh"

module hpq_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic signed [hpq_pkg::VW-1:0] item_value_i,
  input  wire logic [hpq_pkg::FW-1:0]        slot_index_i,
  input  wire logic [hpq_pkg::CW-1:0]        cap_i,
  output hpq_pkg::ram_req_t                  ram_req_o,
  input  wire logic signed [hpq_pkg::VW-1:0] rdata_a_i,
  input  wire logic signed [hpq_pkg::VW-1:0] rdata_b_i,
  output logic                               done_o,
  output logic                               status_o,
  output logic [hpq_pkg::FW-1:0]             position_o,
  output logic signed [hpq_pkg::VW-1:0]      result_value_o
);
  import hpq_pkg::*;

  state_e               state_q, state_d;
  logic [1:0]           op_q, op_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        k_q, k_d;
  logic signed [VW-1:0] cur_q, cur_d;
  logic signed [VW-1:0] res_q, res_d;
  logic                 has2_q, has2_d;
  logic                 done_q, done_d;
  logic                 status_q, status_d;
  logic [FW-1:0]        position_q, position_d;
  logic signed [VW-1:0] result_q, result_d;

  logic [IW-1:0]        cnt_x, cap_x, slot_x, k_x, c_x, c1_x;
  logic                 rise_end;
  logic signed [VW-1:0] big;
  logic [AW-1:0]        big_idx;

  assign cnt_x  = IW'(cnt_q);
  assign cap_x  = IW'(cap_i);
  assign slot_x = IW'(slot_index_i);
  assign k_x    = IW'(k_q);
  assign c_x    = (k_x << 1) + IW'(1);
  assign c1_x   = c_x + IW'(1);

  // larger child; left wins a tie
  always_comb begin
    if (has2_q && (rdata_a_i < rdata_b_i)) begin
      big     = rdata_b_i;
      big_idx = AW'(c1_x);
    end else begin
      big     = rdata_a_i;
      big_idx = AW'(c_x);
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    cur_d      = cur_q;
    res_d      = res_q;
    has2_d     = has2_q;
    done_d     = 1'b0;
    status_d   = status_q;
    position_d = position_q;
    result_d   = result_q;
    ram_req_o  = '0;
    rise_end   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d = opcode_i;
          // error unless a legal branch below takes the item
          done_d     = 1'b1;
          status_d   = 1'b1;
          position_d = '0;
          result_d   = '0;
          case (opcode_i)
            OP_EXTRACT: begin
              if (cnt_q != '0) begin
                done_d            = 1'b0;
                ram_req_o.raddr_a = '0;
                ram_req_o.raddr_b = AW'(cnt_x - IW'(1));
                state_d           = ST_FETCH;
              end
            end
            OP_INSERT: begin
              if (cnt_x < cap_x) begin
                done_d  = 1'b0;
                cur_d   = item_value_i;
                k_d     = AW'(cnt_x);
                cnt_d   = CW'(cnt_x + IW'(1));
                state_d = ST_RISE;
              end
            end
            OP_DELETE: begin
              if ((slot_x != '0) && (slot_x <= cnt_x)) begin
                done_d            = 1'b0;
                ram_req_o.raddr_a = AW'(slot_x - IW'(1));
                ram_req_o.raddr_b = AW'(cnt_x - IW'(1));
                k_d               = AW'(slot_x - IW'(1));
                state_d           = ST_FETCH;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_FETCH: begin
        res_d = rdata_a_i;
        cnt_d = CW'(cnt_x - IW'(1));
        if (op_q == OP_EXTRACT) begin
          if (cnt_x == IW'(1)) begin
            done_d     = 1'b1;
            status_d   = 1'b0;
            position_d = '0;
            result_d   = rdata_a_i;
            state_d    = ST_IDLE;
          end else begin
            cur_d   = rdata_b_i;
            k_d     = '0;
            state_d = ST_SINK;
          end
        end else begin
          // removing the last entry: no sift
          if (k_x == cnt_x - IW'(1)) begin
            done_d     = 1'b1;
            status_d   = 1'b0;
            position_d = '0;
            result_d   = rdata_a_i;
            state_d    = ST_IDLE;
          end else begin
            cur_d   = rdata_b_i;
            state_d = ST_RISE;
          end
        end
      end

      ST_RISE: begin
        if (k_q == '0) begin
          rise_end = 1'b1;
        end else begin
          ram_req_o.raddr_a = (k_q - AW'(1)) >> 1;
          state_d           = ST_RISE_CMP;
        end
      end

      ST_RISE_CMP: begin
        if (rdata_a_i < cur_q) begin
          // move parent down into the hole
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = k_q;
          ram_req_o.wdata = rdata_a_i;
          k_d             = (k_q - AW'(1)) >> 1;
          state_d         = ST_RISE;
        end else begin
          rise_end = 1'b1;
        end
      end

      ST_SINK: begin
        if (c_x >= cnt_x) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = k_q;
          ram_req_o.wdata = cur_q;
          done_d          = 1'b1;
          status_d        = 1'b0;
          position_d      = (op_q == OP_EXTRACT) ? FW'(k_x + IW'(1)) : '0;
          result_d        = res_q;
          state_d         = ST_IDLE;
        end else begin
          ram_req_o.raddr_a = AW'(c_x);
          ram_req_o.raddr_b = AW'(c1_x);
          has2_d            = (c1_x < cnt_x);
          state_d           = ST_SINK_CMP;
        end
      end

      ST_SINK_CMP: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = k_q;
        if (cur_q < big) begin
          // pull larger child up into the hole
          ram_req_o.wdata = big;
          k_d             = big_idx;
          state_d         = ST_SINK;
        end else begin
          ram_req_o.wdata = cur_q;
          done_d          = 1'b1;
          status_d        = 1'b0;
          position_d      = (op_q == OP_EXTRACT) ? FW'(k_x + IW'(1)) : '0;
          result_d        = res_q;
          state_d         = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (rise_end) begin
      if (op_q == OP_INSERT) begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = k_q;
        ram_req_o.wdata = cur_q;
        done_d          = 1'b1;
        status_d        = 1'b0;
        position_d      = FW'(k_x + IW'(1));
        result_d        = '0;
        state_d         = ST_IDLE;
      end else begin
        state_d = ST_SINK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    k_q        <= k_d;
    cur_q      <= cur_d;
    res_q      <= res_d;
    has2_q     <= has2_d;
    status_q   <= status_d;
    position_q <= position_d;
    result_q   <= result_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign position_o     = position_q;
  assign result_value_o = result_q;

  `HPQ_ASSERT(a_cnt_bound, cnt_x <= IW'(DEPTH), "entry count above depth")
  `HPQ_ASSERT(a_done_idle, done_q |-> state_q == ST_IDLE, "result while walk in flight")
  `HPQ_ASSERT_NEVER(a_we_idle, ram_req_o.we && state_q == ST_IDLE, "RAM write while idle")
  `HPQ_ASSERT(a_ins_pos,
              done_q && !status_q && op_q == OP_INSERT |-> position_q != '0,
              "insert gave zero position")
  `HPQ_ASSERT(a_cnt_move,
              !$stable(cnt_q) |-> $past(state_q == ST_IDLE && start) ||
                                  $past(state_q == ST_FETCH),
              "count moved outside accept or fetch")

endmodule
`default_nettype wire

/* rtl/core/max_heap_priority_queue_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Max-heap priority queue unit
// Signed 32-bit max-heap in on-chip RAM: extract max, insert, delete at slot.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  request  | start / busy         | opcode_i, item_value_i, slot_index_i
//  result   | done_o (1-cycle)     | status_o, position_o, result_value_o
//  config   | cfg_we_i             | cfg_wdata_i (capacity limit)
//
//  Errors (empty, full, bad slot, unused opcode): done_o in the cycle after accept.
//  Insert: a read state and a compare state per level climbed, then the closing write.
//  Extract: a fetch, then a read state and a compare state per level sunk, then the
//  closing write. Delete: fetch, climb, sink. Each level costs one read on the heap
//  RAM, whose read data is registered.
//  Reset clears the entry count; RAM contents are not cleared.
//  busy holds off new items while a walk runs; results cannot be stalled.
// ----------------------------------------------------------------------------
module max_heap_priority_queue_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    opcode_i,
  input  wire logic signed [hpq_pkg::VW-1:0] item_value_i,
  input  wire logic [hpq_pkg::FW-1:0]        slot_index_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [hpq_pkg::FW-1:0]        cfg_wdata_i,
  output logic                               done_o,
  output logic                               status_o,
  output logic [hpq_pkg::FW-1:0]             position_o,
  output logic signed [hpq_pkg::VW-1:0]      result_value_o
);
  import hpq_pkg::*;

  logic [FW-1:0]        cap_q;
  logic [IW-1:0]        cap_x;
  logic [CW-1:0]        cap_eff;
  ram_req_t             ram_req;
  logic signed [VW-1:0] rdata_a, rdata_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // clamp the limit to the RAM depth
  assign cap_x   = IW'(cap_q);
  assign cap_eff = (cap_x > IW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_x);

  hpq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .item_value_i   (item_value_i),
    .slot_index_i   (slot_index_i),
    .cap_i          (cap_eff),
    .ram_req_o      (ram_req),
    .rdata_a_i      (rdata_a),
    .rdata_b_i      (rdata_b),
    .done_o         (done_o),
    .status_o       (status_o),
    .position_o     (position_o),
    .result_value_o (result_value_o)
  );

  hpq_ram #(
    .DW    (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_req.we),
    .waddr_i   (ram_req.waddr),
    .wdata_i   (ram_req.wdata),
    .raddr_a_i (ram_req.raddr_a),
    .raddr_b_i (ram_req.raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

endmodule
`default_nettype wire
